/* rtl/core/tsg_pkg.sv */
`timescale 1ns / 1ps

package tsg_pkg;

    localparam int CMD_IN_W = 16;
    localparam int CMD_W    = 16;
    localparam int NUM_CMDS = 4;
    localparam int MAG_W    = 16;
    localparam int DIG_N    = 5;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam longint CMD_HI = (longint'(1) <<< (CMD_W - 1)) - 1;
    localparam longint CMD_LO = -(longint'(1) <<< (CMD_W - 1));

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_PER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PCT  = 2'd3;

    localparam logic [2:0] OP_DOL  = 3'd0;
    localparam logic [2:0] OP_CHR  = 3'd1;
    localparam logic [2:0] OP_NUM  = 3'd2;
    localparam logic [2:0] OP_TAIL = 3'd3;
    localparam logic [2:0] OP_END  = 3'd4;

    localparam logic [7:0] NUM_PCT = 8'd4;

    localparam logic [4:0] PC_ARM  = 5'd0;
    localparam logic [4:0] PC_CMD  = 5'd9;
    localparam logic [4:0] PC_LAST = 5'd20;

    localparam logic [2:0] TAIL_LAST = 3'd4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UM     = 8'h4D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef logic [NUM_CMDS-1:0][CMD_IN_W-1:0] t_cmd_vec;

    typedef struct packed {
        logic go;
        logic armed;
    } t_start;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_emit;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] arg;
    } t_step;

    function automatic t_step script(input logic [4:0] pc);
        t_step s;
        case (pc)
            5'd0:  s = '{op: OP_DOL,  arg: CH_DOLLAR};
            5'd1:  s = '{op: OP_CHR,  arg: CH_UM};
            5'd2:  s = '{op: OP_CHR,  arg: CH_UA};
            5'd3:  s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd4:  s = '{op: OP_CHR,  arg: CH_ONE};
            5'd5:  s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd6:  s = '{op: OP_NUM,  arg: NUM_PCT};
            5'd7:  s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd8:  s = '{op: OP_TAIL, arg: CH_STAR};
            5'd9:  s = '{op: OP_DOL,  arg: CH_DOLLAR};
            5'd10: s = '{op: OP_CHR,  arg: CH_UM};
            5'd11: s = '{op: OP_CHR,  arg: CH_UC};
            5'd12: s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd13: s = '{op: OP_NUM,  arg: 8'd0};
            5'd14: s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd15: s = '{op: OP_NUM,  arg: 8'd1};
            5'd16: s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd17: s = '{op: OP_NUM,  arg: 8'd2};
            5'd18: s = '{op: OP_CHR,  arg: CH_COMMA};
            5'd19: s = '{op: OP_NUM,  arg: 8'd3};
            5'd20: s = '{op: OP_TAIL, arg: CH_STAR};
            default: s = '{op: OP_END, arg: CH_ZERO};
        endcase
        return s;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (CH_ZERO + {4'b0, d}) : (CH_UA + {4'b0, d} - 8'd10);
    endfunction

    function automatic logic [CMD_IN_W-1:0] sat_cmd(input logic [CMD_IN_W-1:0] raw);
        longint v;
        v = longint'(signed'(raw));
        if (v > CMD_HI) v = CMD_HI;
        if (v < CMD_LO) v = CMD_LO;
        return CMD_IN_W'(v);
    endfunction

endpackage

/* rtl/core/tsg_div10.sv */
`timescale 1ns / 1ps

module tsg_div10 (
    input  logic [tsg_pkg::MAG_W-1:0] i_val,
    output logic [tsg_pkg::MAG_W-1:0] o_quo,
    output logic [3:0]                o_rem
);
    import tsg_pkg::*;

    localparam logic [15:0] RECIP10 = 16'd52429;

    logic [31:0]      prod;
    logic [12:0]      quo;
    logic [MAG_W-1:0] quo10;
    logic [MAG_W-1:0] diff;

    // reciprocal multiply, exact for all 16-bit values
    assign prod  = i_val * RECIP10;
    assign quo   = prod[31:19];
    assign quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
    assign diff  = i_val - quo10;
    assign o_rem = diff[3:0];
    assign o_quo = {3'b000, quo};

endmodule

/* rtl/core/tsg_seq.sv */
`timescale 1ns / 1ps

module tsg_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsg_pkg::t_start             i_start,
    input  tsg_pkg::t_cmd_vec           i_cmd,
    input  logic [tsg_pkg::CFG_W-1:0]   i_pct,
    input  logic                        i_take,
    output tsg_pkg::t_emit              o_emit,
    output logic                        o_busy
);
    import tsg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_CONV  = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;
    localparam logic [2:0] S_TAIL  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [4:0]          r_pc, n_pc;
    logic [7:0]          r_csum, n_csum;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [2:0]          r_ndig, n_ndig;
    logic [2:0]          r_didx, n_didx;
    logic [2:0]          r_tidx, n_tidx;
    t_cmd_vec            r_cmd;
    logic [CFG_W-1:0]    r_pct;
    logic [3:0]          r_digs [DIG_N];

    t_step               step;
    logic [CMD_IN_W-1:0] sel_val;
    logic [MAG_W-1:0]    quo;
    logic [3:0]          rem;
    logic [7:0]          tail_ch;

    tsg_div10 u_div10 (
        .i_val (r_mag),
        .o_quo (quo),
        .o_rem (rem)
    );

    assign step    = script(r_pc);
    assign sel_val = r_cmd[step.arg[1:0]];
    assign o_busy  = (r_state != S_IDLE);

    always_comb begin
        case (r_tidx)
            3'd0:    tail_ch = CH_STAR;
            3'd1:    tail_ch = hex_char(r_csum[7:4]);
            3'd2:    tail_ch = hex_char(r_csum[3:0]);
            3'd3:    tail_ch = CH_CR;
            default: tail_ch = CH_LF;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_csum  = r_csum;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_ndig  = r_ndig;
        n_didx  = r_didx;
        n_tidx  = r_tidx;
        o_emit  = '{valid: 1'b0, data: CH_ZERO, last: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_pc    = i_start.armed ? PC_ARM : PC_CMD;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                case (step.op)
                    OP_DOL, OP_CHR: begin
                        o_emit.valid = 1'b1;
                        o_emit.data  = step.arg;
                        if (i_take) begin
                            n_csum = (step.op == OP_DOL) ? 8'd0 : (r_csum ^ step.arg);
                            n_pc   = r_pc + 5'd1;
                        end
                    end
                    OP_NUM: begin
                        if (step.arg == NUM_PCT) begin
                            n_neg = 1'b0;
                            n_mag = {{(MAG_W - CFG_W){1'b0}}, r_pct};
                        end else begin
                            n_neg = sel_val[CMD_IN_W-1];
                            n_mag = sel_val[CMD_IN_W-1] ? MAG_W'(-sel_val) : MAG_W'(sel_val);
                        end
                        n_ndig  = 3'd0;
                        n_state = S_CONV;
                    end
                    OP_TAIL: begin
                        n_tidx  = 3'd0;
                        n_state = S_TAIL;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CONV: begin
                n_ndig = r_ndig + 3'd1;
                n_mag  = quo;
                if (quo == '0) begin
                    n_didx  = r_ndig + 3'd1;
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                o_emit.valid = 1'b1;
                o_emit.data  = CH_MINUS;
                if (i_take) begin
                    n_csum  = r_csum ^ CH_MINUS;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_emit.valid = 1'b1;
                o_emit.data  = CH_ZERO + {4'b0, r_digs[r_didx - 3'd1]};
                if (i_take) begin
                    n_csum = r_csum ^ o_emit.data;
                    n_didx = r_didx - 3'd1;
                    if (r_didx == 3'd1) begin
                        n_pc    = r_pc + 5'd1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_TAIL: begin
                o_emit.valid = 1'b1;
                o_emit.data  = tail_ch;
                o_emit.last  = (r_pc == PC_LAST) && (r_tidx == TAIL_LAST);
                if (i_take) begin
                    n_tidx = r_tidx + 3'd1;
                    if (r_tidx == TAIL_LAST) begin
                        if (r_pc == PC_LAST) begin
                            n_state = S_IDLE;
                        end else begin
                            n_pc    = r_pc + 5'd1;
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc   <= n_pc;
        r_csum <= n_csum;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_ndig <= n_ndig;
        r_didx <= n_didx;
        r_tidx <= n_tidx;
        if (r_state == S_IDLE && i_start.go) begin
            for (int k = 0; k < NUM_CMDS; k++) begin
                r_cmd[k] <= sat_cmd(i_cmd[k]);
            end
            r_pct <= i_pct;
        end
        if (r_state == S_CONV) begin
            r_digs[r_ndig] <= rem;
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start.go |-> (r_state == S_IDLE))
        else $error("start while sequencer busy");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.last && i_take) |=> (r_state == S_IDLE))
        else $error("sequencer not idle after final word");

    a_conv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_ndig < 3'd5))
        else $error("digit count overflow");

    a_digit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_didx != 3'd0 && r_didx <= 3'd5))
        else $error("digit index out of range");

endmodule

/* rtl/core/thruster_sentence_generator.sv */
`timescale 1ns / 1ps

// channel  | handshake                         | payload
// ---------+-----------------------------------+-------------------------------------------
// input    | i_in_valid / o_in_stall           | i_port_main_cmd, i_stbd_main_cmd,
//          |                                   | i_port_bow_cmd, i_stbd_bow_cmd
// output   | o_out_valid / i_out_stall         | o_out_byte, o_last_byte
// config   | i_cfg_we                          | i_cfg_index, i_cfg_data
//
// a held or disabled tick is accepted and yields no word
// an emitting tick steps through each output word, one fetch per number and per checksum
// tail, and one decimal digit at a time in the shared divide-by-10 unit
// reset is synchronous, active low; config returns to enable=1, hold=15, period=20, max=100
// the input stalls while the sequencer runs; output stall pauses it word by word

module thruster_sentence_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [tsg_pkg::CMD_IN_W-1:0] i_port_main_cmd,
    input  logic signed [tsg_pkg::CMD_IN_W-1:0] i_stbd_main_cmd,
    input  logic signed [tsg_pkg::CMD_IN_W-1:0] i_port_bow_cmd,
    input  logic signed [tsg_pkg::CMD_IN_W-1:0] i_stbd_bow_cmd,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_out_byte,
    output logic                               o_last_byte,
    input  logic                               i_cfg_we,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tsg_pkg::CFG_W-1:0]          i_cfg_data
);
    import tsg_pkg::*;

    logic       r_enable;
    logic [4:0] r_startup_hold;
    logic [5:0] r_arm_period;
    logic [6:0] r_max_pct;
    logic [4:0] r_hold_count, n_hold_count;
    logic [5:0] r_arm_count, n_arm_count;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       in_accept;
    logic       seq_busy;
    logic       out_free;
    logic       take;
    t_start     start;
    t_emit      emit;
    t_cmd_vec   cmds;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = seq_busy;
    assign start.go    = in_accept && r_enable && (r_hold_count >= r_startup_hold);
    assign start.armed = (r_arm_count >= r_arm_period);
    assign cmds = {i_stbd_bow_cmd, i_port_bow_cmd, i_stbd_main_cmd, i_port_main_cmd};

    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = emit.valid && out_free;

    tsg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (cmds),
        .i_pct   (r_max_pct),
        .i_take  (take),
        .o_emit  (emit),
        .o_busy  (seq_busy)
    );

    always_comb begin
        n_hold_count = r_hold_count;
        n_arm_count  = r_arm_count;
        if (in_accept && r_enable) begin
            if (r_hold_count < r_startup_hold) begin
                n_hold_count = r_hold_count + 5'd1;
            end else begin
                if (r_hold_count != 5'd31) begin
                    n_hold_count = r_hold_count + 5'd1;
                end
                n_arm_count = start.armed ? 6'd0 : (r_arm_count + 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_startup_hold <= 5'd15;
            r_arm_period   <= 6'd20;
            r_max_pct      <= 7'd100;
            r_hold_count   <= 5'd0;
            r_arm_count    <= 6'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_hold_count <= n_hold_count;
            r_arm_count  <= n_arm_count;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENABLE:  r_enable       <= i_cfg_data[0];
                    REG_HOLD:    r_startup_hold <= i_cfg_data[4:0];
                    REG_ARM_PER: r_arm_period   <= i_cfg_data[5:0];
                    REG_MAX_PCT: r_max_pct      <= i_cfg_data;
                    default:     r_enable       <= r_enable;
                endcase
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= emit.data;
            r_out_last <= emit.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule
